// File: src/scps_pkg.sv
package scps_pkg;

  localparam int unsigned MeasW  = 16;
  localparam int unsigned LimitW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned ClockW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumFlags = 5;

  typedef enum logic [1:0] {
    ModeInit = 2'd0,
    ModeRun  = 2'd1,
    ModeErr  = 2'd2,
    ModeHalt = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPanelVoltMax = 3'd0,
    CfgPanelVoltMin = 3'd1,
    CfgPanelCurrMax = 3'd2,
    CfgBattVoltMax  = 3'd3,
    CfgUpdatePeriod = 3'd4,
    CfgErrorLimit   = 3'd5
  } cfg_idx_e;

  // bit positions in the fault flag word
  localparam int unsigned FlPanelOver  = 0;
  localparam int unsigned FlPanelUnder = 1;
  localparam int unsigned FlOverCurr   = 2;
  localparam int unsigned FlBattOver   = 3;
  localparam int unsigned FlBattOverHw = 4;

  typedef logic [NumFlags-1:0] flags_t;

  localparam logic [LimitW-1:0] PanelVoltMaxRst = 16'd65535;
  localparam logic [LimitW-1:0] PanelVoltMinRst = 16'd0;
  localparam logic [LimitW-1:0] PanelCurrMaxRst = 16'd65535;
  localparam logic [LimitW-1:0] BattVoltMaxRst  = 16'd65535;
  localparam logic [LimitW-1:0] UpdatePeriodRst = 16'd500;
  localparam logic [CountW-1:0] ErrorLimitRst   = 8'd5;

endpackage

// File: src/solar_charger_protection_supervisor.sv
// Channel | Direction | Handshake               | Payload
// in      | sink      | in_valid_i / in_stall_o | tick, sample flag, 3 samples, hw event
// out     | source    | out_valid_o / out_stall_i | mode, 5 flags, drive, pulses, errors
// cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while the output is not stalled; each result passes
// from the input register to the result register.
// Item work between them: compares, a 32-bit add and subtract, an 8-bit saturating increment.
// Reset (rst_ni low, asynchronous) clears mode, flags, counters, drive and LED state and both
// valid bits and returns the limits to their defaults; result data registers are not reset.
// An output stall holds the result; an empty input register takes one more item, then stalls.
module solar_charger_protection_supervisor #(
  parameter int unsigned TICK_MS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                tick_pulse_i,
  input  logic                                sample_ready_i,
  input  logic [scps_pkg::MeasW-1:0]          panel_current_i,
  input  logic [scps_pkg::MeasW-1:0]          panel_voltage_i,
  input  logic [scps_pkg::MeasW-1:0]          battery_voltage_i,
  input  logic                                hw_overvolt_event_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          mode_o,
  output logic                                flag_panel_over_o,
  output logic                                flag_panel_under_o,
  output logic                                flag_overcurrent_o,
  output logic                                flag_batt_over_o,
  output logic                                flag_batt_over_hw_o,
  output logic                                driver_enable_o,
  output logic                                led_on_o,
  output logic                                duty_update_o,
  output logic                                duty_reset_o,
  output logic [scps_pkg::CountW-1:0]         error_total_o,

  input  logic                                cfg_we_i,
  input  logic [scps_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [scps_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  localparam logic [scps_pkg::ClockW-1:0] TickStep = scps_pkg::ClockW'(TICK_MS);

  // configuration
  logic [scps_pkg::LimitW-1:0] pv_max_q, pv_min_q, pc_max_q, bv_max_q, period_q;
  logic [scps_pkg::CountW-1:0] err_limit_q;

  // input register
  logic                        in_valid_q;
  logic                        tick_q, sample_q, hw_evt_q;
  logic [scps_pkg::MeasW-1:0]  cur_in_q, pv_in_q, bv_in_q;

  // supervisor state
  scps_pkg::mode_e             mode_q, mode_d;
  scps_pkg::flags_t            flags_q, flags_d;
  logic [scps_pkg::MeasW-1:0]  cur_q, cur_d, pv_q, pv_d, bv_q, bv_d;
  logic [scps_pkg::ClockW-1:0] elapsed_q, elapsed_d, last_upd_q, last_upd_d;
  logic [scps_pkg::CountW-1:0] err_cnt_q, err_cnt_d;
  logic                        drv_q, drv_d, led_q, led_d;
  logic                        upd_d, rst_d;

  // result register
  logic                        out_valid_q;
  scps_pkg::mode_e             res_mode_q;
  scps_pkg::flags_t            res_flags_q;
  logic                        res_drv_q, res_led_q, res_upd_q, res_rst_q;
  logic [scps_pkg::CountW-1:0] res_err_q;

  logic out_free;
  logic advance;
  logic in_xfer;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  function automatic scps_pkg::flags_t check_limits(
    input scps_pkg::flags_t            f_in,
    input logic [scps_pkg::MeasW-1:0]  cur,
    input logic [scps_pkg::MeasW-1:0]  pv,
    input logic [scps_pkg::MeasW-1:0]  bv,
    input logic [scps_pkg::LimitW-1:0] pv_max,
    input logic [scps_pkg::LimitW-1:0] pv_min,
    input logic [scps_pkg::LimitW-1:0] pc_max,
    input logic [scps_pkg::LimitW-1:0] bv_max
  );
    scps_pkg::flags_t f;
    f = '0;
    f[scps_pkg::FlBattOver]   = f_in[scps_pkg::FlBattOver];
    f[scps_pkg::FlBattOverHw] = f_in[scps_pkg::FlBattOverHw];
    if (pv >= pv_max) begin
      f[scps_pkg::FlPanelOver] = 1'b1;
    end else if (pv <= pv_min) begin
      f[scps_pkg::FlPanelUnder] = 1'b1;
    end
    if (cur >= pc_max) begin
      f[scps_pkg::FlOverCurr] = 1'b1;
    end
    // the software battery flag sticks while the hardware latch is set
    if (bv >= bv_max) begin
      f[scps_pkg::FlBattOver] = 1'b1;
    end else if (!f[scps_pkg::FlBattOverHw]) begin
      f[scps_pkg::FlBattOver] = 1'b0;
    end
    return f;
  endfunction

  always_comb begin
    logic [scps_pkg::ClockW-1:0] since_upd;
    logic [scps_pkg::CountW-1:0] cnt_inc;
    mode_d     = mode_q;
    flags_d    = flags_q;
    cur_d      = cur_q;
    pv_d       = pv_q;
    bv_d       = bv_q;
    elapsed_d  = elapsed_q;
    last_upd_d = last_upd_q;
    err_cnt_d  = err_cnt_q;
    drv_d      = drv_q;
    led_d      = led_q;
    upd_d      = 1'b0;
    rst_d      = 1'b0;
    since_upd  = '0;
    cnt_inc    = (&err_cnt_q) ? err_cnt_q : err_cnt_q + 1'b1;

    // latch the comparator event on every item; an error retry back to init clears it again
    if (hw_evt_q) begin
      flags_d[scps_pkg::FlBattOverHw] = 1'b1;
    end

    if (tick_q) begin
      elapsed_d = elapsed_q + TickStep;
      since_upd = elapsed_d - last_upd_q;
      if (sample_q) begin
        cur_d = cur_in_q;
        pv_d  = pv_in_q;
        bv_d  = bv_in_q;
      end
      unique case (mode_q)
        scps_pkg::ModeInit: begin
          led_d   = 1'b1;
          flags_d = check_limits(flags_d, cur_d, pv_d, bv_d,
                                 pv_max_q, pv_min_q, pc_max_q, bv_max_q);
          if (flags_d == '0) begin
            drv_d  = 1'b1;
            mode_d = scps_pkg::ModeRun;
          end else begin
            mode_d = scps_pkg::ModeErr;
          end
        end
        scps_pkg::ModeRun: begin
          if (sample_q) begin
            flags_d = check_limits(flags_d, cur_d, pv_d, bv_d,
                                   pv_max_q, pv_min_q, pc_max_q, bv_max_q);
          end
          if (flags_d != '0) begin
            mode_d = scps_pkg::ModeErr;
          end else if (since_upd >= scps_pkg::ClockW'(period_q)) begin
            last_upd_d = elapsed_d;
            upd_d      = 1'b1;
          end
        end
        scps_pkg::ModeErr: begin
          rst_d     = 1'b1;
          drv_d     = 1'b0;
          led_d     = 1'b0;
          err_cnt_d = cnt_inc;
          if (cnt_inc >= err_limit_q) begin
            mode_d = scps_pkg::ModeHalt;
          end else begin
            flags_d[scps_pkg::FlBattOverHw] = 1'b0;
            mode_d = scps_pkg::ModeInit;
          end
        end
        scps_pkg::ModeHalt: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_max_q    <= scps_pkg::PanelVoltMaxRst;
      pv_min_q    <= scps_pkg::PanelVoltMinRst;
      pc_max_q    <= scps_pkg::PanelCurrMaxRst;
      bv_max_q    <= scps_pkg::BattVoltMaxRst;
      period_q    <= scps_pkg::UpdatePeriodRst;
      err_limit_q <= scps_pkg::ErrorLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scps_pkg::CfgPanelVoltMax: pv_max_q    <= cfg_wdata_i;
        scps_pkg::CfgPanelVoltMin: pv_min_q    <= cfg_wdata_i;
        scps_pkg::CfgPanelCurrMax: pc_max_q    <= cfg_wdata_i;
        scps_pkg::CfgBattVoltMax:  bv_max_q    <= cfg_wdata_i;
        scps_pkg::CfgUpdatePeriod: period_q    <= cfg_wdata_i;
        scps_pkg::CfgErrorLimit:   err_limit_q <= cfg_wdata_i[scps_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q   <= tick_pulse_i;
      sample_q <= sample_ready_i;
      hw_evt_q <= hw_overvolt_event_i;
      cur_in_q <= panel_current_i;
      pv_in_q  <= panel_voltage_i;
      bv_in_q  <= battery_voltage_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= scps_pkg::ModeInit;
      flags_q    <= '0;
      cur_q      <= '0;
      pv_q       <= '0;
      bv_q       <= '0;
      elapsed_q  <= '0;
      last_upd_q <= '0;
      err_cnt_q  <= '0;
      drv_q      <= 1'b0;
      led_q      <= 1'b0;
    end else if (advance) begin
      mode_q     <= mode_d;
      flags_q    <= flags_d;
      cur_q      <= cur_d;
      pv_q       <= pv_d;
      bv_q       <= bv_d;
      elapsed_q  <= elapsed_d;
      last_upd_q <= last_upd_d;
      err_cnt_q  <= err_cnt_d;
      drv_q      <= drv_d;
      led_q      <= led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_mode_q  <= mode_d;
      res_flags_q <= flags_d;
      res_drv_q   <= drv_d;
      res_led_q   <= led_d;
      res_upd_q   <= upd_d;
      res_rst_q   <= rst_d;
      res_err_q   <= err_cnt_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mode_o              = res_mode_q;
  assign flag_panel_over_o   = res_flags_q[scps_pkg::FlPanelOver];
  assign flag_panel_under_o  = res_flags_q[scps_pkg::FlPanelUnder];
  assign flag_overcurrent_o  = res_flags_q[scps_pkg::FlOverCurr];
  assign flag_batt_over_o    = res_flags_q[scps_pkg::FlBattOver];
  assign flag_batt_over_hw_o = res_flags_q[scps_pkg::FlBattOverHw];
  assign driver_enable_o     = res_drv_q;
  assign led_on_o            = res_led_q;
  assign duty_update_o       = res_upd_q;
  assign duty_reset_o        = res_rst_q;
  assign error_total_o       = res_err_q;

endmodule

// File: src/scps_checker.sv
module scps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  mode_o,
  input logic                        flag_panel_over_o,
  input logic                        flag_panel_under_o,
  input logic                        driver_enable_o,
  input logic                        led_on_o,
  input logic                        duty_update_o,
  input logic                        duty_reset_o,
  input logic [scps_pkg::CountW-1:0] error_total_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_o) && $stable(error_total_o))
    else $error("stalled result changed");

  a_halt_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_o == scps_pkg::ModeHalt |-> !driver_enable_o && !led_on_o)
    else $error("drive active while halted");

  a_upd_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duty_update_o |-> mode_o == scps_pkg::ModeRun && driver_enable_o
      && !duty_reset_o)
    else $error("duty update outside running");

  a_rst_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duty_reset_o |-> !driver_enable_o && error_total_o != '0
      && (mode_o == scps_pkg::ModeInit || mode_o == scps_pkg::ModeHalt))
    else $error("duty reset without error exit");

  a_panel_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(flag_panel_over_o && flag_panel_under_o))
    else $error("panel over and under both set");

endmodule

bind solar_charger_protection_supervisor scps_checker u_scps_checker (.*);
